// ===== rtl/hfq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfq_pkg
// Shared types and constants of the heightfield height query unit.
// ----------------------------------------------------------------------------
package hfq_pkg;

    localparam int MAX_GRID_SAMPLES = 129;
    localparam int HM_DEPTH         = MAX_GRID_SAMPLES * MAX_GRID_SAMPLES;
    localparam int ADDR_W           = $clog2(HM_DEPTH);
    localparam int SAMPLE_W         = 16;
    localparam int READ_PORTS       = 3;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_GRID_CELLS     = 3'd0,
        CFG_ORIGIN_X       = 3'd1,
        CFG_ORIGIN_Z       = 3'd2,
        CFG_INV_SPACING    = 3'd3,
        CFG_ELEVATION_BASE = 3'd4,
        CFG_ELEVATION_STEP = 3'd5
    } cfg_index_t;

    // One access to the height store: an optional write and three reads.
    typedef struct packed {
        logic                                 we;
        logic [ADDR_W-1:0]                    waddr;
        logic [SAMPLE_W-1:0]                  wdata;
        logic [READ_PORTS-1:0][ADDR_W-1:0]    raddr;
    } mem_req_t;

endpackage

// ===== rtl/hfq_height_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfq_height_store
// Height sample memory held as three identical copies, so one cycle can read
// three corners of a cell while every write updates all copies.
// ----------------------------------------------------------------------------
module hfq_height_store (
    input  logic                                                    clk,
    input  logic                                                    en,
    input  hfq_pkg::mem_req_t                                       req,
    output logic [hfq_pkg::READ_PORTS-1:0][hfq_pkg::SAMPLE_W-1:0]   rd
);

    logic [hfq_pkg::SAMPLE_W-1:0] mem0 [hfq_pkg::HM_DEPTH];
    logic [hfq_pkg::SAMPLE_W-1:0] mem1 [hfq_pkg::HM_DEPTH];
    logic [hfq_pkg::SAMPLE_W-1:0] mem2 [hfq_pkg::HM_DEPTH];

    // Write all copies; each copy serves one registered read port.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (req.we)
            begin
                mem0[req.waddr] <= req.wdata;
                mem1[req.waddr] <= req.wdata;
                mem2[req.waddr] <= req.wdata;
            end
            rd[0] <= mem0[req.raddr[0]];
            rd[1] <= mem1[req.raddr[1]];
            rd[2] <= mem2[req.raddr[2]];
        end
    end

endmodule

// ===== rtl/heightfield_triangle_height_query_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heightfield_triangle_height_query_unit
// Loads a grid of raw heights and answers interpolated world heights.
// ----------------------------------------------------------------------------
// The unit takes one word per cycle while the output is not held, either a
// sample write or a position query, and returns one word per query; writes
// give no result. The rate of one word per cycle is set by the ten-stage
// pipeline, in which the corner reads use three copies of the height memory
// so the three corners of a triangle come out of the store in the same cycle.
// A stall on the output freezes the whole pipeline. A write is seen by every
// query taken after it.
module heightfield_triangle_height_query_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        req_type,
    input  logic [14:0] sample_index,
    input  logic [15:0] sample_value,
    input  logic signed [31:0] query_x,
    input  logic signed [31:0] query_z,
    output logic        out_valid,
    input  logic        out_stall,
    output logic signed [31:0] height,
    output logic        outside
);

    localparam logic [16:0] ONE_Q16 = 17'h10000;

    // Configuration registers.
    logic [7:0]  grid_cells_reg;
    logic [31:0] origin_x_reg;
    logic [31:0] origin_z_reg;
    logic [31:0] inv_spacing_reg;
    logic [31:0] elevation_base_reg;
    logic [31:0] elevation_step_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_cells_reg     <= 8'd128;
            origin_x_reg       <= 32'd0;
            origin_z_reg       <= 32'd0;
            inv_spacing_reg    <= 32'd65536;
            elevation_base_reg <= 32'd0;
            elevation_step_reg <= 32'd16777216;
        end
        else if (cfg_we)
        begin
            unique case (hfq_pkg::cfg_index_t'(cfg_index))
                hfq_pkg::CFG_GRID_CELLS:     grid_cells_reg     <= cfg_wdata[7:0];
                hfq_pkg::CFG_ORIGIN_X:       origin_x_reg       <= cfg_wdata;
                hfq_pkg::CFG_ORIGIN_Z:       origin_z_reg       <= cfg_wdata;
                hfq_pkg::CFG_INV_SPACING:    inv_spacing_reg    <= cfg_wdata;
                hfq_pkg::CFG_ELEVATION_BASE: elevation_base_reg <= cfg_wdata;
                hfq_pkg::CFG_ELEVATION_STEP: elevation_step_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // The whole pipeline moves together unless the result word is held.
    logic advance;
    logic out_valid_reg;
    assign advance  = !(out_valid_reg && out_stall);
    assign in_stall = !advance;

    // Valid and query flags of stages 0 to 8.
    logic [8:0] v_reg;
    logic [8:0] q_reg;

    // Stage 0: input capture.
    logic [14:0] idx0_reg, idx1_reg, idx2_reg;
    logic [15:0] val0_reg, val1_reg, val2_reg;
    logic [31:0] qx0_reg, qz0_reg;

    // Stage 1: offsets from the grid corner.
    logic [31:0] dx1_reg, dz1_reg;
    logic        neg1_reg, neg2_reg;
    logic [32:0] offx_next, offz_next;

    assign offx_next = {qx0_reg[31], qx0_reg} - {origin_x_reg[31], origin_x_reg};
    assign offz_next = {qz0_reg[31], qz0_reg} - {origin_z_reg[31], origin_z_reg};

    // Stage 2: grid coordinates in Q32.32.
    logic [63:0] px2_reg, pz2_reg;

    // Stage 3: cell, triangle, addresses and weights.
    logic [7:0]  cells;
    logic [7:0]  size;
    logic [6:0]  col, row;
    logic [15:0] fx, fz;
    logic [16:0] fsum;
    logic [14:0] base, a00, a10, a01, a11;
    logic        outside_next;
    logic [2:0][16:0] w_next;
    hfq_pkg::mem_req_t req_next, req_reg;
    logic [2:0][16:0] w3_reg, w4_reg;
    logic        out3_reg, out4_reg, out5_reg, out6_reg, out7_reg, out8_reg;

    always_comb
    begin
        if (grid_cells_reg < 8'd2)
            cells = 8'd2;
        else if (grid_cells_reg > 8'(hfq_pkg::MAX_GRID_SAMPLES - 1))
            cells = 8'(hfq_pkg::MAX_GRID_SAMPLES - 1);
        else
            cells = grid_cells_reg;
        size = cells + 8'd1;
        outside_next = neg2_reg || (px2_reg[63:32] >= {24'd0, cells})
                                || (pz2_reg[63:32] >= {24'd0, cells});
        col  = outside_next ? 7'd0 : px2_reg[38:32];
        row  = outside_next ? 7'd0 : pz2_reg[38:32];
        fx   = px2_reg[31:16];
        fz   = pz2_reg[31:16];
        fsum = {1'b0, fx} + {1'b0, fz};
        base = {8'd0, col} + ({8'd0, row} * {7'd0, size});
        a00  = base;
        a10  = base + 15'd1;
        a01  = base + {7'd0, size};
        a11  = base + {7'd0, size} + 15'd1;

        req_next.we    = v_reg[2] && !q_reg[2] && (idx2_reg < 15'(hfq_pkg::HM_DEPTH));
        req_next.waddr = idx2_reg;
        req_next.wdata = val2_reg;

        // Equal parity splits along the main diagonal, else the other one.
        if (col[0] == row[0])
        begin
            req_next.raddr[0] = a00;
            req_next.raddr[1] = a11;
            if (fx > fz)
            begin
                req_next.raddr[2] = a10;
                w_next[0] = ONE_Q16 - {1'b0, fx};
                w_next[1] = {1'b0, fz};
                w_next[2] = {1'b0, fx} - {1'b0, fz};
            end
            else
            begin
                req_next.raddr[2] = a01;
                w_next[0] = ONE_Q16 - {1'b0, fz};
                w_next[1] = {1'b0, fx};
                w_next[2] = {1'b0, fz} - {1'b0, fx};
            end
        end
        else
        begin
            req_next.raddr[0] = a10;
            req_next.raddr[1] = a01;
            if (fsum <= ONE_Q16)
            begin
                req_next.raddr[2] = a00;
                w_next[0] = {1'b0, fx};
                w_next[1] = {1'b0, fz};
                w_next[2] = ONE_Q16 - fsum;
            end
            else
            begin
                req_next.raddr[2] = a11;
                w_next[0] = ONE_Q16 - {1'b0, fz};
                w_next[1] = ONE_Q16 - {1'b0, fx};
                w_next[2] = fsum - ONE_Q16;
            end
        end
    end

    // Stage 4: corner samples from the store.
    logic [2:0][15:0] rd;

    hfq_height_store u_store (
        .clk (clk),
        .en  (advance),
        .req (req_reg),
        .rd  (rd)
    );

    // Stage 5 to 9: weighting, sum, scale, round and saturate.
    logic [2:0][32:0] m5_reg;
    logic [31:0] r6_reg;
    logic [63:0] p7_reg;
    logic [40:0] rnd8_reg;
    logic [64:0] rnd_sum;
    logic [42:0] hsum;
    logic [31:0] height_reg;
    logic        outside_reg;
    logic [31:0] height_next;

    assign rnd_sum = {1'b0, p7_reg} + 65'd8388608;
    assign hsum    = {{11{elevation_base_reg[31]}}, elevation_base_reg} + {2'd0, rnd8_reg};

    always_comb
    begin
        if (out8_reg)
            height_next = 32'h7FFF_FFFF;
        else if (!hsum[42] && (hsum[41:31] != 11'd0))
            height_next = 32'h7FFF_FFFF;
        else if (hsum[42] && (hsum[41:31] != 11'h7FF))
            height_next = 32'h8000_0000;
        else
            height_next = hsum[31:0];
    end

    // Control flags of the pipeline.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg         <= '0;
            q_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            v_reg         <= {v_reg[7:0], in_valid};
            q_reg         <= {q_reg[7:0], req_type};
            out_valid_reg <= v_reg[8] && q_reg[8];
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            idx0_reg <= sample_index;
            val0_reg <= sample_value;
            qx0_reg  <= query_x;
            qz0_reg  <= query_z;

            idx1_reg <= idx0_reg;
            val1_reg <= val0_reg;
            dx1_reg  <= offx_next[32] ? 32'd0 : offx_next[31:0];
            dz1_reg  <= offz_next[32] ? 32'd0 : offz_next[31:0];
            neg1_reg <= (offx_next[32] || offz_next[32]) && (inv_spacing_reg != 32'd0);

            idx2_reg <= idx1_reg;
            val2_reg <= val1_reg;
            px2_reg  <= dx1_reg * inv_spacing_reg;
            pz2_reg  <= dz1_reg * inv_spacing_reg;
            neg2_reg <= neg1_reg;

            req_reg  <= req_next;
            w3_reg   <= w_next;
            out3_reg <= outside_next;

            w4_reg   <= w3_reg;
            out4_reg <= out3_reg;

            m5_reg[0] <= w4_reg[0] * rd[0];
            m5_reg[1] <= w4_reg[1] * rd[1];
            m5_reg[2] <= w4_reg[2] * rd[2];
            out5_reg  <= out4_reg;

            r6_reg   <= 32'({1'b0, m5_reg[0]} + {1'b0, m5_reg[1]} + {1'b0, m5_reg[2]});
            out6_reg <= out5_reg;

            p7_reg   <= elevation_step_reg * r6_reg;
            out7_reg <= out6_reg;

            rnd8_reg <= rnd_sum[64:24];
            out8_reg <= out7_reg;

            height_reg  <= height_next;
            outside_reg <= out8_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign height    = height_reg;
    assign outside   = outside_reg;

    // An outside answer always carries the maximum height.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && outside |-> height == 32'h7FFF_FFFF)
        else $error("outside result without maximum height");

    // Barycentric weights of an inside query sum to one.
    assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[3] && q_reg[3] && !out3_reg |->
        (18'(w3_reg[0]) + 18'(w3_reg[1]) + 18'(w3_reg[2])) == 18'(ONE_Q16))
        else $error("triangle weights do not sum to one");

    // A held pipeline keeps its corner samples.
    assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> (rd === $past(rd)))
        else $error("corner samples changed during a stall");

    // Only write words reach the store write port.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_reg.we |-> v_reg[3] && !q_reg[3])
        else $error("store write without a write word");

endmodule
